[hdl/osfi_pkg.sv]
// shared types, constants and arithmetic helpers for the observer regulator
// no dependencies; used by the divider, datapath, controller and top level
`default_nettype none

package osfi_pkg;

    localparam int VU_W       = 15;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int COEF_W     = 16;
    localparam int OPND_W     = 24;
    localparam int PROD_W     = COEF_W + OPND_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int COEF_FRAC  = 14;
    localparam int RND_W      = ACC_W - COEF_FRAC;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC - 1);

    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_OFFSET    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_AMPLITUDE = 4'd3;

    localparam logic [VU_W-1:0] RST_SAT_LOW       = 15'd0;
    localparam logic [VU_W-1:0] RST_SAT_HIGH      = 15'd20480;
    localparam logic [VU_W-1:0] RST_MID_OFFSET    = 15'd10240;
    localparam logic [VU_W-1:0] RST_REF_AMPLITUDE = 15'd4096;

    typedef enum logic [3:0] {
        C_K0, C_NK1, C_NK2, C_A11, C_B1, C_A21, C_A22, C_B2, C_L1, C_L2
    } t_coef;

    typedef enum logic [2:0] {
        OP_INTEG, OP_EST1, OP_EST2, OP_UAPL, OP_INNOV
    } t_opnd;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_CLR, ACC_PRE1, ACC_PRE2, ACC_ADD
    } t_acc_op;

    typedef enum logic [3:0] {
        WR_NONE, WR_INTEG, WR_UPHYS, WR_PRED1, WR_PRED2, WR_EST1, WR_EST2, WR_INNOV
    } t_wr;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_coef   coef;
        t_opnd   opnd;
        t_acc_op acc_op;
        t_wr     wr;
        logic    div_start;
        logic    div_ref;
        logic    cap_eff;
        logic    cap_ref;
        logic    push;
    } t_dp_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
    } t_dp_stat;

    // q2.14 coefficients, feedback gains stored negated so the mac only adds
    function automatic logic signed [COEF_W-1:0] coef_value(input t_coef c);
        logic signed [COEF_W-1:0] v;
        case (c)
            C_K0:    v = 16'sd3736;
            C_NK1:   v = 16'sd16723;
            C_NK2:   v = -16'sd10227;
            C_A11:   v = 16'sd15279;
            C_B1:    v = -16'sd1930;
            C_A21:   v = -16'sd18770;
            C_A22:   v = 16'sd7470;
            C_B2:    v = 16'sd1312;
            C_L1:    v = -16'sd8247;
            C_L2:    v = 16'sd16196;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [RND_W-1:0] x);
        logic signed [19:0] r;
        if (&x[RND_W-1:19] || ~|x[RND_W-1:19]) begin
            r = x[19:0];
        end else if (x[RND_W-1]) begin
            r = {1'b1, 19'b0};
        end else begin
            r = {1'b0, {19{1'b1}}};
        end
        return r;
    endfunction

    function automatic logic signed [23:0] sat24(input logic signed [25:0] x);
        logic signed [23:0] r;
        if (&x[25:23] || ~|x[25:23]) begin
            r = x[23:0];
        end else if (x[25]) begin
            r = {1'b1, 23'b0};
        end else begin
            r = {1'b0, {23{1'b1}}};
        end
        return r;
    endfunction

    // dac input range: raise to low limit, cap at high limit, floor at zero
    function automatic logic [VU_W-1:0] dac_clamp(input logic signed [16:0] v,
                                                  input logic [VU_W-1:0] lo,
                                                  input logic [VU_W-1:0] hi);
        logic signed [16:0] t;
        logic signed [16:0] lo_s;
        logic signed [16:0] hi_s;
        lo_s = {2'b0, lo};
        hi_s = {2'b0, hi};
        t = v;
        if (t < lo_s) t = lo_s;
        if (t > hi_s) t = hi_s;
        if (t[16]) t = '0;
        return t[VU_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hdl/osfi_div.sv]
// radix-2 restoring divider for dac code scaling: floor(max_code * v / full_scale)
// depends on osfi_pkg; one quotient bit per cycle
`default_nettype none

module osfi_div
    import osfi_pkg::*;
#(
    parameter int DAC_MAX_CODE = 255
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [VU_W-1:0]   i_value,
    input  wire logic [VU_W-1:0]   i_scale,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [CODE_W-1:0]      o_code
);

    localparam int QW = $clog2(DAC_MAX_CODE + 1);
    localparam int DW = QW + VU_W;
    localparam int CW = $clog2(QW + 1);

    logic [DW-1:0]      r_rem;
    logic [DW-1:0]      r_den;
    logic [QW-1:0]      r_quo;
    logic [CW-1:0]      r_cnt;
    logic               r_zero;
    logic               r_done;
    logic               w_fit;
    logic [QW+CODE_W-1:0] w_ext;

    assign w_fit = (r_rem >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(QW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CW'(1);
                r_done <= (r_cnt == CW'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= DW'(DAC_MAX_CODE) * DW'(i_value);
            r_den  <= DW'(i_scale) << (QW - 1);
            r_quo  <= '0;
            r_zero <= (i_scale == '0);
        end else if (r_cnt != '0) begin
            if (w_fit) begin
                r_rem <= r_rem - r_den;
            end
            r_quo <= {r_quo[QW-2:0], w_fit};
            r_den <= r_den >> 1;
        end
    end

    assign w_ext  = {{CODE_W{1'b0}}, r_quo};
    assign o_code = r_zero ? '0 : w_ext[CODE_W-1:0];
    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;

endmodule

`default_nettype wire

[hdl/osfi_dp.sv]
// datapath: config registers, plant state, shared multiplier and accumulator,
// dac divider and result registers; depends on osfi_pkg and osfi_div
`default_nettype none

module osfi_dp
    import osfi_pkg::*;
#(
    parameter int DAC_MAX_CODE = 255
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_ref_high,
    input  wire logic signed [15:0]    i_sample,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    output logic [CODE_W-1:0]          o_effort_code,
    output logic [CODE_W-1:0]          o_reference_code
);

    logic [VU_W-1:0]         r_sat_low;
    logic [VU_W-1:0]         r_sat_high;
    logic [VU_W-1:0]         r_mid_offset;
    logic [VU_W-1:0]         r_ref_amplitude;

    logic signed [19:0]      r_est1;
    logic signed [19:0]      r_est2;
    logic signed [23:0]      r_integ;
    logic signed [15:0]      r_ref_lvl;
    logic signed [19:0]      r_pred1;
    logic signed [19:0]      r_pred2;

    logic                    r_ref_high;
    logic signed [15:0]      r_sample;
    logic [VU_W-1:0]         r_uphys;
    logic signed [20:0]      r_innov;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [CODE_W-1:0]       r_code_eff;
    logic [CODE_W-1:0]       r_code_ref;
    logic [CODE_W-1:0]       r_out_eff;
    logic [CODE_W-1:0]       r_out_ref;

    logic signed [15:0]      w_half;
    logic signed [15:0]      w_ref;
    logic signed [25:0]      w_integ_sum;
    logic signed [ACC_W-1:0] w_rnd_sum;
    logic signed [RND_W-1:0] w_round;
    logic signed [RND_W:0]   w_up_raw;
    logic signed [RND_W:0]   w_hi_ext;
    logic signed [RND_W:0]   w_lo_ext;
    logic signed [RND_W:0]   w_up_clamp;
    logic [VU_W-1:0]         w_uphys;
    logic signed [15:0]      w_uapl;
    logic signed [20:0]      w_innov;
    logic signed [OPND_W-1:0] w_opnd;
    logic signed [COEF_W-1:0] w_coef;
    logic signed [PROD_W-1:0] w_prod;
    logic [VU_W-1:0]         w_div_value;
    logic [VU_W-1:0]         w_eff_v;
    logic [VU_W-1:0]         w_ref_v;
    logic signed [16:0]      w_ref_volt;
    logic [CODE_W-1:0]       w_div_code;
    logic                    w_div_busy;
    logic                    w_div_done;

    // reference and integrator
    assign w_half      = {2'b0, r_ref_amplitude[VU_W-1:1]};
    assign w_ref       = r_ref_high ? w_half : -w_half;
    assign w_integ_sum = {{2{r_integ[23]}}, r_integ} + {{10{w_ref[15]}}, w_ref}
                       - {{10{r_sample[15]}}, r_sample};

    // round half up to the voltage format
    assign w_rnd_sum = r_acc + ROUND_HALF;
    assign w_round   = w_rnd_sum[ACC_W-1:COEF_FRAC];

    // effort plus offset, limited high then low
    assign w_up_raw = {w_round[RND_W-1], w_round} + {{(RND_W-VU_W+1){1'b0}}, r_mid_offset};
    assign w_hi_ext = {{(RND_W-VU_W+1){1'b0}}, r_sat_high};
    assign w_lo_ext = {{(RND_W-VU_W+1){1'b0}}, r_sat_low};

    always_comb begin
        w_up_clamp = w_up_raw;
        if (w_up_clamp > w_hi_ext) w_up_clamp = w_hi_ext;
        if (w_up_clamp < w_lo_ext) w_up_clamp = w_lo_ext;
    end

    assign w_uphys = w_up_clamp[VU_W-1:0];
    assign w_uapl  = $signed({1'b0, r_uphys}) - $signed({1'b0, r_mid_offset});
    assign w_innov = {{5{r_sample[15]}}, r_sample} - {r_pred2[19], r_pred2};

    // shared multiplier operands
    always_comb begin
        case (i_cmd.opnd)
            OP_INTEG: w_opnd = r_integ;
            OP_EST1:  w_opnd = {{4{r_est1[19]}}, r_est1};
            OP_EST2:  w_opnd = {{4{r_est2[19]}}, r_est2};
            OP_UAPL:  w_opnd = {{8{w_uapl[15]}}, w_uapl};
            OP_INNOV: w_opnd = {{3{r_innov[20]}}, r_innov};
            default:  w_opnd = '0;
        endcase
    end

    assign w_coef = coef_value(i_cmd.coef);
    assign w_prod = w_coef * w_opnd;

    // dac inputs
    assign w_eff_v     = dac_clamp({2'b0, r_uphys}, r_sat_low, r_sat_high);
    assign w_ref_volt  = {r_ref_lvl[15], r_ref_lvl} + {2'b0, r_mid_offset};
    assign w_ref_v     = dac_clamp(w_ref_volt, r_sat_low, r_sat_high);
    assign w_div_value = i_cmd.div_ref ? w_ref_v : w_eff_v;

    osfi_div #(
        .DAC_MAX_CODE(DAC_MAX_CODE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_value (w_div_value),
        .i_scale (r_sat_high),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_code  (w_div_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_low       <= RST_SAT_LOW;
            r_sat_high      <= RST_SAT_HIGH;
            r_mid_offset    <= RST_MID_OFFSET;
            r_ref_amplitude <= RST_REF_AMPLITUDE;
            r_est1          <= '0;
            r_est2          <= '0;
            r_integ         <= '0;
            r_ref_lvl       <= '0;
            r_pred1         <= '0;
            r_pred2         <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SAT_LOW:       r_sat_low       <= i_cfg_data[VU_W-1:0];
                    REG_SAT_HIGH:      r_sat_high      <= i_cfg_data[VU_W-1:0];
                    REG_MID_OFFSET:    r_mid_offset    <= i_cfg_data[VU_W-1:0];
                    REG_REF_AMPLITUDE: r_ref_amplitude <= i_cfg_data[VU_W-1:0];
                    default: ;
                endcase
            end
            case (i_cmd.wr)
                WR_INTEG: begin
                    r_ref_lvl <= w_ref;
                    r_integ   <= sat24(w_integ_sum);
                end
                WR_PRED1: r_pred1 <= sat20(w_round);
                WR_PRED2: r_pred2 <= sat20(w_round);
                WR_EST1:  r_est1  <= sat20(w_round);
                WR_EST2:  r_est2  <= sat20(w_round);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ref_high <= i_ref_high;
            r_sample   <= i_sample;
        end
        if (i_cmd.wr == WR_UPHYS) begin
            r_uphys <= w_uphys;
        end
        if (i_cmd.wr == WR_INNOV) begin
            r_innov <= w_innov;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_prod;
        end
        case (i_cmd.acc_op)
            ACC_CLR:  r_acc <= '0;
            ACC_PRE1: r_acc <= {{(ACC_W-20-COEF_FRAC){r_pred1[19]}}, r_pred1,
                                {COEF_FRAC{1'b0}}};
            ACC_PRE2: r_acc <= {{(ACC_W-20-COEF_FRAC){r_pred2[19]}}, r_pred2,
                                {COEF_FRAC{1'b0}}};
            ACC_ADD:  r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            default: ;
        endcase
        if (i_cmd.cap_eff) begin
            r_code_eff <= w_div_code;
        end
        if (i_cmd.cap_ref) begin
            r_code_ref <= w_div_code;
        end
        if (i_cmd.push) begin
            r_out_eff <= r_code_eff;
            r_out_ref <= r_code_ref;
        end
    end

    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.div_done  = w_div_done;
    assign o_effort_code    = r_out_eff;
    assign o_reference_code = r_out_ref;

endmodule

`default_nettype wire

[hdl/osfi_ctrl.sv]
// controller: sequences the multiply-accumulate steps, the dac divisions and
// the output register handshake; depends on osfi_pkg
`default_nettype none

module osfi_ctrl
    import osfi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     i_kind,
    input  wire logic     i_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_ready,
    output logic          o_valid,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_K_INTEG, S_K_M0, S_K_M1, S_K_M2, S_K_A, S_K_UPHYS,
        S_K_P1, S_K_P2, S_K_WP1, S_K_P3, S_K_P4, S_K_P5, S_K_WP2,
        S_K_DE, S_K_DR, S_OUT,
        S_C_INNOV, S_C_M1, S_C_A1, S_C_WE1, S_C_A2, S_C_WE2
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                w_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = i_kind ? S_C_INNOV : S_K_INTEG;
                end
            end
            S_K_INTEG: begin
                w_cmd.wr     = WR_INTEG;
                w_cmd.acc_op = ACC_CLR;
                n_state      = S_K_M0;
            end
            S_K_M0: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_K0;
                w_cmd.opnd   = OP_INTEG;
                n_state      = S_K_M1;
            end
            S_K_M1: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_NK1;
                w_cmd.opnd   = OP_EST1;
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_M2;
            end
            S_K_M2: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_NK2;
                w_cmd.opnd   = OP_EST2;
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_A;
            end
            S_K_A: begin
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_UPHYS;
            end
            S_K_UPHYS: begin
                w_cmd.wr     = WR_UPHYS;
                w_cmd.acc_op = ACC_CLR;
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_A11;
                w_cmd.opnd   = OP_EST1;
                n_state      = S_K_P1;
            end
            S_K_P1: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_B1;
                w_cmd.opnd   = OP_UAPL;
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_P2;
            end
            S_K_P2: begin
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_WP1;
            end
            S_K_WP1: begin
                w_cmd.wr     = WR_PRED1;
                w_cmd.acc_op = ACC_CLR;
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_A21;
                w_cmd.opnd   = OP_EST1;
                n_state      = S_K_P3;
            end
            S_K_P3: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_A22;
                w_cmd.opnd   = OP_EST2;
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_P4;
            end
            S_K_P4: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_B2;
                w_cmd.opnd   = OP_UAPL;
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_P5;
            end
            S_K_P5: begin
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_K_WP2;
            end
            S_K_WP2: begin
                w_cmd.wr        = WR_PRED2;
                w_cmd.div_start = 1'b1;
                n_state         = S_K_DE;
            end
            S_K_DE: begin
                if (i_stat.div_done) begin
                    w_cmd.cap_eff   = 1'b1;
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_ref   = 1'b1;
                    n_state         = S_K_DR;
                end
            end
            S_K_DR: begin
                if (i_stat.div_done) begin
                    w_cmd.cap_ref = 1'b1;
                    n_state       = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    w_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_C_INNOV: begin
                w_cmd.wr     = WR_INNOV;
                w_cmd.acc_op = ACC_PRE1;
                n_state      = S_C_M1;
            end
            S_C_M1: begin
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_L1;
                w_cmd.opnd   = OP_INNOV;
                n_state      = S_C_A1;
            end
            S_C_A1: begin
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_C_WE1;
            end
            S_C_WE1: begin
                w_cmd.wr     = WR_EST1;
                w_cmd.acc_op = ACC_PRE2;
                w_cmd.mul_en = 1'b1;
                w_cmd.coef   = C_L2;
                w_cmd.opnd   = OP_INNOV;
                n_state      = S_C_A2;
            end
            S_C_A2: begin
                w_cmd.acc_op = ACC_ADD;
                n_state      = S_C_WE2;
            end
            S_C_WE2: begin
                w_cmd.wr = WR_EST2;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (w_cmd.push) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = w_cmd;

endmodule

`default_nettype wire

[hdl/observer_state_feedback_integral_core.sv]
// top level of the state feedback regulator with integrator and current observer
// depends on osfi_pkg, osfi_ctrl, osfi_dp (which holds osfi_div)
//
// usage:
//   input channel (i_valid/o_ready) carries i_kind, i_ref_high, i_sample.
//   kind 0 is a control sample: it updates reference and integrator, forms the
//   clamped effort, stores the predicted state and returns one result on the
//   output channel (o_valid/i_ready): o_effort_code and o_reference_code.
//   kind 1 is a correction sample: it updates both estimates and returns nothing.
//   a control sample is worked through in order: multiply-accumulate steps
//   on the single shared multiplier, two dac divisions of the effort and the
//   reference on one restoring divider, then the load of the output register.
//   o_ready is high only while no item is in work; a finished result sits in
//   an output register, so the next item is taken while the receiver stalls.
//   a second result waits in the block until the first one is transferred.
//   config port (i_cfg_valid/o_cfg_ready) is always ready; index 0 sat_low,
//   1 sat_high, 2 mid_offset, 3 ref_amplitude, others ignored. write it only
//   while idle. reset restores register defaults and clears the plant state.
`default_nettype none

module observer_state_feedback_integral_core
    import osfi_pkg::*;
#(
    parameter int DAC_MAX_CODE = 255
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_kind,
    input  wire logic                  i_ref_high,
    input  wire logic signed [15:0]    i_sample,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [CODE_W-1:0]          o_effort_code,
    output logic [CODE_W-1:0]          o_reference_code,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    osfi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_cmd   (w_cmd)
    );

    osfi_dp #(
        .DAC_MAX_CODE(DAC_MAX_CODE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_ref_high       (i_ref_high),
        .i_sample         (i_sample),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_effort_code    (o_effort_code),
        .o_reference_code (o_reference_code)
    );

    // a new result appears only as the sequencer leaves its busy states
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> !$past(o_ready))
        else $error("result raised while input side was idle");

    // divider never left running when idle
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !w_stat.div_busy)
        else $error("divider busy while idle");

    // a division is started only on a free divider
    a_div_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_stat.div_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for observer_state_feedback_integral_core
// depends on osfi_pkg and the core; a local regulator twin predicts the dac codes
// of every control sample and checks each output transfer in order
`default_nettype none

module testbench;
    import osfi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DAC_FULL     = 255;
    localparam int SETTLE_WAIT  = 48;
    localparam int IDLE_LIMIT   = 2000;
    localparam int PHASE_ITEMS  = 120;
    localparam int WINDUP_ITEMS = 400;

    localparam logic KIND_CONTROL    = 1'b0;
    localparam logic KIND_CORRECTION = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SPARE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_SPARE  = 4'd15;

    // q2.14 plant, gain and observer coefficients
    localparam longint M_A11 = 15279;
    localparam longint M_A21 = -18770;
    localparam longint M_A22 = 7470;
    localparam longint M_B1  = -1930;
    localparam longint M_B2  = 1312;
    localparam longint M_K1  = -16723;
    localparam longint M_K2  = 10227;
    localparam longint M_K0  = 3736;
    localparam longint M_L1  = -8247;
    localparam longint M_L2  = 16196;

    typedef struct packed {
        logic [CODE_W-1:0] effort;
        logic [CODE_W-1:0] reference;
    } t_code_pair;

    class regulator_twin;
        longint sat_lo, sat_hi, mid_off, ref_amp;
        longint est1, est2, integ, ref_lvl, pred1, pred2;
        t_code_pair code_queue[$];
        int fails;

        function new();
            sat_lo  = longint'(RST_SAT_LOW);
            sat_hi  = longint'(RST_SAT_HIGH);
            mid_off = longint'(RST_MID_OFFSET);
            ref_amp = longint'(RST_REF_AMPLITUDE);
            est1 = 0;
            est2 = 0;
            integ = 0;
            ref_lvl = 0;
            pred1 = 0;
            pred2 = 0;
            fails = 0;
        endfunction

        function longint round_q14(longint x);
            return (x + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        endfunction

        function longint clip(longint x, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) << (bits - 1)) - 1;
            lo = -hi - 1;
            if (x > hi) return hi;
            if (x < lo) return lo;
            return x;
        endfunction

        function logic [CODE_W-1:0] dac(longint v);
            if (v < sat_lo) v = sat_lo;
            if (v > sat_hi) v = sat_hi;
            if (v < 0) v = 0;
            if (sat_hi == 0) return '0;
            return CODE_W'((longint'(DAC_FULL) * v) / sat_hi);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            longint v;
            v = longint'(data[VU_W-1:0]);
            case (idx)
                REG_SAT_LOW:       sat_lo = v;
                REG_SAT_HIGH:      sat_hi = v;
                REG_MID_OFFSET:    mid_off = v;
                REG_REF_AMPLITUDE: ref_amp = v;
                default: ;
            endcase
        endfunction

        function void take_item(logic kind, logic ref_hi, logic signed [15:0] smp);
            longint y;
            longint innov;
            longint acc;
            longint u_phys;
            longint u_apl;
            t_code_pair codes;
            y = longint'(smp);
            if (kind == KIND_CORRECTION) begin
                innov = y - pred2;
                est1 = clip(pred1 + round_q14(M_L1 * innov), 20);
                est2 = clip(pred2 + round_q14(M_L2 * innov), 20);
                return;
            end
            ref_lvl = ref_hi ? (ref_amp >> 1) : -(ref_amp >> 1);
            integ = clip(integ + ref_lvl - y, 24);
            acc = M_K0 * integ - (M_K1 * est1 + M_K2 * est2);
            u_phys = round_q14(acc) + mid_off;
            if (u_phys > sat_hi) u_phys = sat_hi;
            if (u_phys < sat_lo) u_phys = sat_lo;
            u_apl = u_phys - mid_off;
            pred1 = clip(round_q14(M_A11 * est1 + M_B1 * u_apl), 20);
            pred2 = clip(round_q14(M_A21 * est1 + M_A22 * est2 + M_B2 * u_apl), 20);
            codes.effort = dac(u_phys);
            codes.reference = dac(ref_lvl + mid_off);
            code_queue.push_back(codes);
        endfunction

        function void check_codes(logic [CODE_W-1:0] eff, logic [CODE_W-1:0] refc);
            t_code_pair want;
            if (code_queue.size() == 0) begin
                $error("unexpected result: effort_code %0d reference_code %0d", eff, refc);
                fails++;
                return;
            end
            want = code_queue.pop_front();
            if (eff !== want.effort) begin
                $error("effort_code: expected %0d, got %0d", want.effort, eff);
                fails++;
            end
            if (refc !== want.reference) begin
                $error("reference_code: expected %0d, got %0d", want.reference, refc);
                fails++;
            end
        endfunction

        function int pending();
            return code_queue.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_kind = 1'b0;
    logic                  i_ref_high = 1'b0;
    logic signed [15:0]    i_sample = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [CODE_W-1:0]     o_effort_code;
    logic [CODE_W-1:0]     o_reference_code;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    regulator_twin twin = new();
    bit            steady = 1'b0;
    int            idle_cycles = 0;

    observer_state_feedback_integral_core #(
        .DAC_MAX_CODE(DAC_FULL)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_ref_high      (i_ref_high),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_effort_code   (o_effort_code),
        .o_reference_code(o_reference_code),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid & o_ready) === 1'b1 || (o_valid & i_ready) === 1'b1 ||
            (i_cfg_valid & o_cfg_ready) === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side
    initial begin
        int stall;
        forever begin
            stall = steady ? 0 : $urandom_range(3, 0);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            twin.check_codes(o_effort_code, o_reference_code);
        end
    end

    task automatic send_item(input logic kind, input logic ref_hi,
                             input logic signed [15:0] smp);
        int gap;
        gap = steady ? 0 : $urandom_range(3, 0);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_kind     <= kind;
        i_ref_high <= ref_hi;
        i_sample   <= smp;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        twin.take_item(kind, ref_hi, smp);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'(value);
        data[CFG_DATA_W-1] = 1'($urandom_range(1, 0));
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        twin.apply_reg(idx, data);
    endtask

    task automatic program_regs(input int lo, input int hi, input int mid, input int amp);
        write_reg(REG_SAT_LOW, lo);
        write_reg(REG_SAT_HIGH, hi);
        write_reg(REG_MID_OFFSET, mid);
        write_reg(REG_REF_AMPLITUDE, amp);
        write_reg(CFG_IDX_W'($urandom_range(REG_LAST_SPARE, REG_FIRST_SPARE)), $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // hold off input until every result is out and the block has gone quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (twin.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] s;
        case ($urandom_range(3, 0))
            0: s = 16'($urandom);
            1: s = 16'(int'($urandom_range(1023, 0)) - 512);
            2: begin
                case ($urandom_range(3, 0))
                    0:       s = 16'sh7fff;
                    1:       s = 16'sh8000;
                    2:       s = 16'sh0000;
                    default: s = 16'shffff;
                endcase
            end
            default: s = 16'(int'($urandom_range(16383, 0)) - 8192);
        endcase
        return s;
    endfunction

    task automatic run_random(input int count);
        int n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(9, 0) < 7) begin
                // normal loop: control sample followed by its correction
                send_item(KIND_CONTROL, 1'($urandom_range(1, 0)), pick_sample());
                send_item(KIND_CORRECTION, 1'($urandom_range(1, 0)), pick_sample());
                n += 2;
            end else begin
                send_item(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), pick_sample());
                n += 1;
            end
        end
    endtask

    task automatic run_windup(input int count);
        repeat (count) send_item(KIND_CONTROL, 1'b1, 16'sh8000);
        repeat (count) send_item(KIND_CONTROL, 1'b0, 16'sh7fff);
        repeat (count / 4) begin
            send_item(KIND_CONTROL, 1'b1, 16'sh8000);
            send_item(KIND_CORRECTION, 1'b0, 16'sh7fff);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corrections with no prediction stored, then controls and mixed pairs
        send_item(KIND_CORRECTION, 1'b0, 16'sh0000);
        send_item(KIND_CORRECTION, 1'b1, 16'sh7fff);
        send_item(KIND_CORRECTION, 1'b0, 16'sh8000);
        send_item(KIND_CONTROL, 1'b1, 16'sh0000);
        send_item(KIND_CONTROL, 1'b0, 16'sh7fff);
        send_item(KIND_CONTROL, 1'b1, 16'sh8000);
        send_item(KIND_CONTROL, 1'b0, 16'shffff);
        send_item(KIND_CORRECTION, 1'b1, 16'sh0001);
        send_item(KIND_CONTROL, 1'b1, 16'sh5555);
        send_item(KIND_CORRECTION, 1'b0, 16'shaaaa);
        send_item(KIND_CONTROL, 1'b0, 16'shaaaa);
        send_item(KIND_CORRECTION, 1'b1, 16'sh5555);
        settle();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0: program_regs(0, 32767, 16384, 32767);
                1: program_regs(32767, 1, 0, 0);
                2: program_regs(0, 0, 10240, 4096);
                3: program_regs(4096, 16384, 10240, 8192);
                4: program_regs(0, 20480, 10240, 4096);
                5: program_regs(0, 32767, 32767, 1);
                6: program_regs($urandom_range(32767, 0), $urandom_range(32767, 0),
                                $urandom_range(32767, 0), $urandom_range(32767, 0));
                default: program_regs($urandom_range(12288, 0), $urandom_range(32767, 8192),
                                      $urandom_range(20480, 4096), $urandom_range(16384, 0));
            endcase
            steady = (p % 3 == 2);
            if (p == 0) begin
                run_windup(WINDUP_ITEMS);
            end
            run_random(PHASE_ITEMS);
            settle();
        end

        if (twin.fails == 0 && twin.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hdl/osfi_pkg.sv
hdl/osfi_div.sv
hdl/osfi_dp.sv
hdl/osfi_ctrl.sv
hdl/observer_state_feedback_integral_core.sv
tb/testbench.sv
